/* hdl/gcn_pkg.sv */
// ----------------------------------------------------------------------------
// gcn_pkg: shared types and constants for greedy class NMS
// Detection record layout, register indexes and the minimum box size.
// ----------------------------------------------------------------------------
package gcn_pkg;

	localparam int unsigned CfgIdxW = 1;
	localparam logic [CfgIdxW-1:0] REG_SCORE_THR = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_IOU_THR   = 1'd1;
	localparam logic [15:0] MIN_SIZE_Q4 = 16'd16;
	localparam logic [8:0]  IOU_THR_RESET = 9'd115;

	typedef struct packed {
		logic [7:0]  class_id;
		logic [15:0] left;
		logic [15:0] top;
		logic [15:0] width;
		logic [15:0] height;
		logic [15:0] score;
		logic [5:0]  index;
	} det_t;

	// Broadcast from the sequencer to every cell of the chain
	typedef struct packed {
		logic shift_in;   // insert a new record in score order, lower ones shift down
		logic step;       // present head record to chain, shift out
		logic clear;      // drop all contents
	} cell_ctl_t;

endpackage

/* hdl/gcn_if.sv */
// ----------------------------------------------------------------------------
// gcn_in_if / gcn_out_if / gcn_cfg_if: handshake channels
// Valid/ready channels for detections, results and register writes.
// ----------------------------------------------------------------------------
interface gcn_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  class_id;
	logic [15:0] box_left;
	logic [15:0] box_top;
	logic [15:0] box_width;
	logic [15:0] box_height;
	logic [15:0] score;
	logic        set_end;
	modport source (output valid, class_id, box_left, box_top, box_width, box_height,
		score, set_end, input ready);
	modport sink (input valid, class_id, box_left, box_top, box_width, box_height,
		score, set_end, output ready);
endinterface

interface gcn_out_if;
	logic        valid;
	logic        ready;
	logic        kept_valid;
	logic [7:0]  out_class;
	logic [15:0] out_left;
	logic [15:0] out_top;
	logic [15:0] out_width;
	logic [15:0] out_height;
	logic [15:0] out_score;
	logic [5:0]  source_index;
	logic        run_last;
	logic        overflow;
	modport source (output valid, kept_valid, out_class, out_left, out_top, out_width,
		out_height, out_score, source_index, run_last, overflow, input ready);
	modport sink (input valid, kept_valid, out_class, out_left, out_top, out_width,
		out_height, out_score, source_index, run_last, overflow, output ready);
endinterface

interface gcn_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hdl/greedy_class_nms.sv */
// ----------------------------------------------------------------------------
// greedy_class_nms: per-class greedy non-maximum suppression
// Loads detections into a self-sorting cell chain, then suppresses against
// a chain of kept-box cells and streams the kept boxes out.
// ----------------------------------------------------------------------------
// Each accepted detection is filtered (score nonzero and at least
// score_threshold, width and height at least 1.0) and inserted into a chain
// of MAX_DETECTIONS sort cells; loading runs at one item a cycle while the
// block is in its load state. On the item with set_end the block stops
// taking items: the sorted chain shifts out one candidate at a time (a step
// into the candidate register, then a wait while the three-stage IoU
// pipeline in every kept cell settles, all cells compared at once). A kept
// candidate is appended to the kept chain and held until the next keep or
// the end of the run shows whether it is the last; the output register must
// drain before the next candidate is stepped out. Overflowing detections are
// dropped and flagged on every result of the run; an empty run gives one
// result with kept_valid 0.
// ----------------------------------------------------------------------------
module greedy_class_nms #(
	parameter int unsigned MAX_DETECTIONS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	gcn_in_if.sink    in_ch,
	gcn_out_if.source out_ch,
	gcn_cfg_if.sink   cfg
);
	localparam int unsigned N  = MAX_DETECTIONS;
	localparam int unsigned CW = $clog2(N + 1);

	typedef enum logic [3:0] {
		ST_LOAD = 4'b0001,
		ST_CAND = 4'b0010,
		ST_WAIT = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t state_q;
	logic [15:0] score_thr_q;
	logic [8:0]  iou_thr_q;
	logic [CW-1:0] count_q, left_q, kcount_q;
	logic overflow_q, any_kept_q;
	logic [1:0] wait_q;
	gcn_pkg::det_t cand_q;

	// configuration
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_thr_q <= 16'd0;
			iou_thr_q <= gcn_pkg::IOU_THR_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				gcn_pkg::REG_SCORE_THR: score_thr_q <= cfg.data;
				gcn_pkg::REG_IOU_THR:   iou_thr_q <= cfg.data[8:0];
				default: ;
			endcase
		end
	end

	// input filter
	logic acc, good, store;
	gcn_pkg::det_t new_det;
	assign in_ch.ready = (state_q == ST_LOAD);
	assign acc = in_ch.valid && in_ch.ready;
	assign good = (in_ch.score != 16'd0) && (in_ch.score >= score_thr_q)
		&& (in_ch.box_width >= gcn_pkg::MIN_SIZE_Q4)
		&& (in_ch.box_height >= gcn_pkg::MIN_SIZE_Q4);
	assign store = acc && good && (count_q < CW'(N));
	always_comb begin
		new_det.class_id = in_ch.class_id;
		new_det.left = in_ch.box_left;
		new_det.top = in_ch.box_top;
		new_det.width = in_ch.box_width;
		new_det.height = in_ch.box_height;
		new_det.score = in_ch.score;
		new_det.index = 6'(count_q);
	end

	// sort chain
	gcn_pkg::cell_ctl_t sctl;
	logic          s_valid [N+1];
	gcn_pkg::det_t s_det   [N+1];
	logic          s_beats [N+1];
	logic do_step;
	logic run_clear;
	assign sctl.shift_in = store;
	assign sctl.step = do_step;
	assign sctl.clear = run_clear;
	assign s_valid[N] = 1'b0;
	assign s_det[N] = '0;
	assign s_beats[N] = 1'b0;

	// virtual cell above the head: never valid, never beaten
	logic          top_valid;
	gcn_pkg::det_t top_det;
	assign top_valid = 1'b0;
	assign top_det = '0;

	for (genvar i = 0; i < N; i++) begin : g_sort
		logic pv, pb;
		gcn_pkg::det_t pd;
		if (i == 0) begin : g_head
			assign pv = top_valid;
			assign pd = top_det;
			assign pb = 1'b0;
		end else begin : g_body
			assign pv = s_valid[i-1];
			assign pd = s_det[i-1];
			assign pb = s_beats[i-1];
		end
		gcn_sort_cell u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(sctl), .new_det(new_det),
			.prev_valid(pv), .prev_det(pd), .prev_beats(pb),
			.next_valid(s_valid[i+1]), .next_det(s_det[i+1]),
			.valid(s_valid[i]), .det(s_det[i]), .beats(s_beats[i])
		);
	end
	// sort cell valid update: a cell fills when it was valid, or a record moves
	// into it, or the new record lands here (first beaten cell of the chain)

	// kept chain
	logic k_hit [N];
	logic k_load;
	logic any_hit;
	for (genvar i = 0; i < N; i++) begin : g_kept
		gcn_kept_cell u_cell (
			.clk(clk), .arst_n(arst_n), .clear(run_clear),
			.load(k_load && (kcount_q == CW'(i))), .load_det(cand_q),
			.cand(cand_q), .iou_thr(iou_thr_q),
			.hit(k_hit[i])
		);
	end
	always_comb begin
		any_hit = 1'b0;
		for (int i = 0; i < N; i++) any_hit = any_hit | k_hit[i];
	end

	// output register
	logic ovalid_q;
	gcn_pkg::det_t odet_q;
	logic okv_q, olast_q, oovf_q;
	assign out_ch.valid = ovalid_q;
	assign out_ch.kept_valid = okv_q;
	assign out_ch.out_class = odet_q.class_id;
	assign out_ch.out_left = odet_q.left;
	assign out_ch.out_top = odet_q.top;
	assign out_ch.out_width = odet_q.width;
	assign out_ch.out_height = odet_q.height;
	assign out_ch.out_score = odet_q.score;
	assign out_ch.source_index = odet_q.index;
	assign out_ch.run_last = olast_q;
	assign out_ch.overflow = oovf_q;

	// run_last needs lookahead, so a kept result is held in pend_* and sent
	// when the next keep or the run end shows
	logic keep, last_cand;
	logic pend_q;
	gcn_pkg::det_t pend_det_q;
	logic emit_empty, emit_mid, emit_last;
	assign keep = (state_q == ST_WAIT) && (wait_q == 2'd0) && !any_hit;
	assign last_cand = (left_q == '0);
	assign do_step = (state_q == ST_CAND) && (left_q != '0) && !ovalid_q;
	assign k_load = keep;
	assign run_clear = (state_q == ST_EMIT) && !ovalid_q;
	assign emit_empty = (state_q == ST_CAND) && last_cand && !ovalid_q && !any_kept_q;
	assign emit_last = (state_q == ST_CAND) && last_cand && !ovalid_q && pend_q;
	assign emit_mid = keep && pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			left_q <= '0;
			kcount_q <= '0;
			overflow_q <= 1'b0;
			any_kept_q <= 1'b0;
			wait_q <= 2'd0;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && out_ch.ready) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					if (acc) begin
						if (store) count_q <= count_q + 1'b1;
						if (good && !store) overflow_q <= 1'b1;
						if (in_ch.set_end) begin
							left_q <= store ? count_q + 1'b1 : count_q;
							state_q <= ST_CAND;
						end
					end
				end
				ST_CAND: begin
					if (!ovalid_q) begin
						if (left_q == '0) begin
							state_q <= ST_EMIT;
						end else begin
							left_q <= left_q - 1'b1;
							wait_q <= 2'd3;
							state_q <= ST_WAIT;
						end
					end
				end
				ST_WAIT: begin
					if (wait_q != 2'd0) begin
						wait_q <= wait_q - 1'b1;
					end else begin
						if (!any_hit) begin
							kcount_q <= kcount_q + 1'b1;
							any_kept_q <= 1'b1;
						end
						state_q <= ST_CAND;
					end
				end
				ST_EMIT: begin
					if (!ovalid_q) begin
						count_q <= '0;
						kcount_q <= '0;
						overflow_q <= 1'b0;
						any_kept_q <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
			if (emit_empty || emit_mid || emit_last) ovalid_q <= 1'b1;
		end
	end

	// candidate capture and kept-result staging
	always_ff @(posedge clk) begin
		if (do_step) cand_q <= s_det[0];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (keep) begin
			pend_q <= 1'b1;
		end else if ((state_q == ST_CAND) && last_cand && !ovalid_q) begin
			pend_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (keep) pend_det_q <= cand_q;
	end
	// result payload: empty run, pending flushed by a new keep, or run end
	always_ff @(posedge clk) begin
		if (emit_empty) begin
			odet_q <= '0;
			okv_q <= 1'b0;
			olast_q <= 1'b1;
			oovf_q <= overflow_q;
		end else if (emit_mid) begin
			odet_q <= pend_det_q;
			okv_q <= 1'b1;
			olast_q <= 1'b0;
			oovf_q <= overflow_q;
		end else if (emit_last) begin
			odet_q <= pend_det_q;
			okv_q <= 1'b1;
			olast_q <= 1'b1;
			oovf_q <= overflow_q;
		end
	end
endmodule

/* hdl/gcn_sort_cell.sv */
// ----------------------------------------------------------------------------
// gcn_sort_cell: one slot of the insertion-sort chain
// Holds one record; on insertion keeps its own, takes the new record or the
// neighbour's, keeping score order, highest first and ties in arrival order.
// ----------------------------------------------------------------------------
module gcn_sort_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  gcn_pkg::cell_ctl_t  ctl,
	input  gcn_pkg::det_t       new_det,
	input  logic                prev_valid,
	input  gcn_pkg::det_t       prev_det,
	input  logic                prev_beats,   // new record goes above the upstream cell
	input  logic                next_valid,
	input  gcn_pkg::det_t       next_det,
	output logic                valid,
	output gcn_pkg::det_t       det,
	output logic                beats
);
	logic          valid_q;
	gcn_pkg::det_t det_q;
	logic          prev_moves;
	logic          lands;

	// new item goes before this one when this cell is empty or the new score is strictly higher (stable)
	assign beats = !valid_q || (new_det.score > det_q.score);
	// upstream record shifts down into this cell
	assign prev_moves = prev_valid && prev_beats;
	// first beaten cell takes the new record
	assign lands = beats && !prev_beats;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.shift_in) begin
			valid_q <= valid_q || prev_moves || lands;
		end else if (ctl.step) begin
			valid_q <= next_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift_in) begin
			if (prev_moves) det_q <= prev_det;
			else if (lands) det_q <= new_det;
		end else if (ctl.step) begin
			det_q <= next_det;
		end
	end

	assign valid = valid_q;
	assign det   = det_q;
endmodule

/* hdl/gcn_kept_cell.sv */
// ----------------------------------------------------------------------------
// gcn_kept_cell: one slot of the kept-box chain
// Holds a kept record and tests it against the candidate over a short
// pipeline: overlap, then products, then the threshold compare.
// ----------------------------------------------------------------------------
module gcn_kept_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clear,
	input  logic                load,
	input  gcn_pkg::det_t       load_det,
	input  gcn_pkg::det_t       cand,
	input  logic [8:0]          iou_thr,
	output logic                hit       // registered at the end of the overlap, product and compare pipeline
);
	logic          valid_q;
	gcn_pkg::det_t det_q;
	logic [16:0]   ar, br, ab, bb, lo_x, hi_x, lo_y, hi_y;
	logic [15:0]   ox, oy;
	logic          same;
	logic [15:0]   ox_s1, oy_s1, aw_s1, ah_s1, bw_s1, bh_s1;
	logic          same_s1;
	logic [31:0]   inter_s2, a1_s2, a2_s2;
	logic          same_s2;
	logic [32:0]   uni;
	logic [41:0]   lhs, rhs;

	always_comb begin
		ar = {1'b0, cand.left} + {1'b0, cand.width};
		br = {1'b0, det_q.left} + {1'b0, det_q.width};
		ab = {1'b0, cand.top} + {1'b0, cand.height};
		bb = {1'b0, det_q.top} + {1'b0, det_q.height};
		lo_x = (cand.left > det_q.left) ? {1'b0, cand.left} : {1'b0, det_q.left};
		hi_x = (ar < br) ? ar : br;
		lo_y = (cand.top > det_q.top) ? {1'b0, cand.top} : {1'b0, det_q.top};
		hi_y = (ab < bb) ? ab : bb;
		// overlap never exceeds the smaller width, so 16 bits hold it
		ox = (hi_x > lo_x) ? 16'(hi_x - lo_x) : 16'd0;
		oy = (hi_y > lo_y) ? 16'(hi_y - lo_y) : 16'd0;
		same = valid_q && (cand.class_id == det_q.class_id);
	end

	always_ff @(posedge clk) begin
		ox_s1 <= ox; oy_s1 <= oy;
		aw_s1 <= cand.width; ah_s1 <= cand.height;
		bw_s1 <= det_q.width; bh_s1 <= det_q.height;
		same_s1 <= same;
		inter_s2 <= ox_s1 * oy_s1;
		a1_s2 <= aw_s1 * ah_s1;
		a2_s2 <= bw_s1 * bh_s1;
		same_s2 <= same_s1;
	end

	always_comb begin
		uni = {1'b0, a1_s2} + {1'b0, a2_s2} - {1'b0, inter_s2};
		lhs = {2'b0, inter_s2, 8'd0};
		rhs = 42'(uni) * 42'(iou_thr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit <= 1'b0;
		end else begin
			hit <= same_s2 && (uni != 33'd0) && (lhs > rhs);
			if (clear) valid_q <= 1'b0;
			else if (load) valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) det_q <= load_det;
	end
endmodule

/* tb/sv/tb_greedy_class_nms.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_greedy_class_nms: self-checking bench for per-class greedy NMS
// Drives detection sets through the valid/ready input channel, predicts the
// kept boxes of each set and checks every result field in order.
// ----------------------------------------------------------------------------
module tb_greedy_class_nms;

	localparam int MAX_DET = 64;

	typedef struct {
		logic [7:0]  class_id;
		logic [15:0] left;
		logic [15:0] top;
		logic [15:0] width;
		logic [15:0] height;
		logic [15:0] score;
		logic        set_end;
	} det_item_t;

	typedef struct {
		logic        kept_valid;
		logic [7:0]  cls;
		logic [15:0] left;
		logic [15:0] top;
		logic [15:0] width;
		logic [15:0] height;
		logic [15:0] score;
		logic [5:0]  src;
		logic        run_last;
		logic        ovf;
	} kept_box_t;

	logic clk;
	logic arst_n;

	gcn_in_if  in_ch ();
	gcn_out_if out_ch ();
	gcn_cfg_if cfg ();

	greedy_class_nms #(.MAX_DETECTIONS(MAX_DET)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	// Predictor state: own copy of the store and registers
	det_item_t   stored_dets[$];
	logic        set_overflow;
	logic [15:0] min_score;
	logic [8:0]  iou_q8;

	det_item_t   pending_items[$];   // items waiting for the driver
	kept_box_t   expected_kept[$];   // predicted results, oldest first

	int  mismatches;
	int  items_sent;
	int  results_seen;
	int  sets_closed;
	longint cycle_count;

	// Idling control
	int  send_idle_pct;
	int  recv_stall_pct;
	int  hold_off_cycles;   // long receiver hold-off, counted in its own process
	bit  cfg_busy;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Overlap along one axis, edges held in 17 bits
	function automatic longint unsigned axis_span(logic [15:0] a0, logic [15:0] alen,
			logic [15:0] b0, logic [15:0] blen);
		logic [16:0] a1;
		logic [16:0] b1;
		logic [16:0] lo;
		logic [16:0] hi;
		a1 = {1'b0, a0} + alen;
		b1 = {1'b0, b0} + blen;
		lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
		hi = (a1 < b1) ? a1 : b1;
		return (hi > lo) ? longint'(hi - lo) : 0;
	endfunction

	// Candidate c is suppressed by kept box k when IoU exceeds iou_q8/256
	function automatic bit overlaps_too_much(det_item_t c, det_item_t k);
		longint unsigned ox, oy, inter, ac, ak, uni;
		ox = axis_span(c.left, c.width, k.left, k.width);
		oy = axis_span(c.top, c.height, k.top, k.height);
		inter = ox * oy;
		ac = longint'(c.width) * longint'(c.height);
		ak = longint'(k.width) * longint'(k.height);
		uni = ac + ak - inter;
		if (uni == 0)
			return 1'b0;
		return (inter * 256) > (longint'(iou_q8) * uni);
	endfunction

	// Load one detection and, on set_end, predict the kept boxes of the set
	task automatic load_detection(det_item_t d);
		int order[$];
		int kept_idx[$];
		int pos;
		bit keep;
		kept_box_t r;
		if (d.score != 0 && d.score >= min_score &&
				d.width >= gcn_pkg::MIN_SIZE_Q4 && d.height >= gcn_pkg::MIN_SIZE_Q4) begin
			if (stored_dets.size() < MAX_DET)
				stored_dets.insert(stored_dets.size(), d);
			else
				set_overflow = 1'b1;
		end
		if (!d.set_end)
			return;
		// stable sort, highest confidence first
		for (int i = 0; i < stored_dets.size(); i++) begin
			pos = order.size();
			while (pos > 0 && stored_dets[order[pos-1]].score < stored_dets[i].score)
				pos--;
			order.insert(pos, i);
		end
		foreach (order[i]) begin
			keep = 1'b1;
			foreach (kept_idx[j])
				if (keep && stored_dets[order[i]].class_id == stored_dets[kept_idx[j]].class_id &&
						overlaps_too_much(stored_dets[order[i]], stored_dets[kept_idx[j]]))
					keep = 1'b0;
			if (keep)
				kept_idx.insert(kept_idx.size(), order[i]);
		end
		if (kept_idx.size() == 0) begin
			r = '{default: '0};
			r.run_last = 1'b1;
			r.ovf = set_overflow;
			expected_kept.insert(expected_kept.size(), r);
		end else begin
			foreach (kept_idx[i]) begin
				r.kept_valid = 1'b1;
				r.cls    = stored_dets[kept_idx[i]].class_id;
				r.left   = stored_dets[kept_idx[i]].left;
				r.top    = stored_dets[kept_idx[i]].top;
				r.width  = stored_dets[kept_idx[i]].width;
				r.height = stored_dets[kept_idx[i]].height;
				r.score  = stored_dets[kept_idx[i]].score;
				r.src    = 6'(kept_idx[i]);
				r.run_last = (i == kept_idx.size() - 1);
				r.ovf    = set_overflow;
				expected_kept.insert(expected_kept.size(), r);
			end
		end
		stored_dets.delete();
		set_overflow = 1'b0;
		sets_closed++;
	endtask

	// Append one item to the driver's queue
	task automatic queue_item(det_item_t d);
		pending_items.insert(pending_items.size(), d);
	endtask

	// Driver: offers queued items, prediction happens on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.class_id <= '0;
			in_ch.box_left <= '0;
			in_ch.box_top <= '0;
			in_ch.box_width <= '0;
			in_ch.box_height <= '0;
			in_ch.score <= '0;
			in_ch.set_end <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				load_detection(pending_items.pop_front());
				items_sent++;
			end
			// next offer: either keep holding the current item or present a new one
			if (in_ch.valid && !in_ch.ready) begin
				// hold, payload unchanged
			end else if (pending_items.size() > 0 && !cfg_busy &&
					$urandom_range(99) >= send_idle_pct) begin
				in_ch.valid <= 1'b1;
				in_ch.class_id <= pending_items[0].class_id;
				in_ch.box_left <= pending_items[0].left;
				in_ch.box_top <= pending_items[0].top;
				in_ch.box_width <= pending_items[0].width;
				in_ch.box_height <= pending_items[0].height;
				in_ch.score <= pending_items[0].score;
				in_ch.set_end <= pending_items[0].set_end;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off counter
	always @(posedge clk) begin
		if (hold_off_cycles > 0)
			hold_off_cycles <= hold_off_cycles - 1;
	end

	// Monitor: random back-pressure, long hold-off on request, field check
	always @(posedge clk or negedge arst_n) begin
		kept_box_t e;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			cycle_count++;
			if (out_ch.valid && out_ch.ready) begin
				results_seen++;
				if (expected_kept.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] unexpected result, class %0d idx %0d", $realtime,
							out_ch.out_class, out_ch.source_index);
				end else begin
					e = expected_kept.pop_front();
					if (out_ch.kept_valid !== e.kept_valid || out_ch.out_class !== e.cls ||
							out_ch.out_left !== e.left || out_ch.out_top !== e.top ||
							out_ch.out_width !== e.width || out_ch.out_height !== e.height ||
							out_ch.out_score !== e.score || out_ch.source_index !== e.src ||
							out_ch.run_last !== e.run_last || out_ch.overflow !== e.ovf) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("[%0t] mismatch exp kv%0d c%0d l%h t%h w%h h%h s%h i%0d rl%0d o%0d",
								$realtime, e.kept_valid, e.cls, e.left, e.top, e.width,
								e.height, e.score, e.src, e.run_last, e.ovf);
							$display("            got kv%0d c%0d l%h t%h w%h h%h s%h i%0d rl%0d o%0d",
								out_ch.kept_valid, out_ch.out_class, out_ch.out_left,
								out_ch.out_top, out_ch.out_width, out_ch.out_height,
								out_ch.out_score, out_ch.source_index, out_ch.run_last,
								out_ch.overflow);
						end
					end
				end
			end
			if (hold_off_cycles > 0)
				out_ch.ready <= 1'b0;
			else
				out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Timeout watchdog
	always @(posedge clk) begin
		if (cycle_count > 600000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic det_item_t rand_det(bit last_one);
		det_item_t d;
		d.class_id = 8'($urandom_range(3));
		d.left     = 16'($urandom_range(2000));
		d.top      = 16'($urandom_range(2000));
		d.width    = 16'($urandom_range(16, 600));
		d.height   = 16'($urandom_range(16, 600));
		d.score    = 16'($urandom_range(1, 65535));
		d.set_end  = last_one;
		// some noise: full-range fields and invalid boxes
		if ($urandom_range(9) == 0) begin
			d.class_id = 8'($urandom);
			d.left = 16'($urandom);
			d.top = 16'($urandom);
			d.width = 16'($urandom);
			d.height = 16'($urandom);
			d.score = 16'($urandom);
		end else if ($urandom_range(9) == 0) begin
			d.width = 16'($urandom_range(15));
		end
		return d;
	endfunction

	function automatic det_item_t mk(logic [7:0] c, logic [15:0] l, logic [15:0] t,
			logic [15:0] w, logic [15:0] h, logic [15:0] s, logic e);
		det_item_t d;
		d = '{c, l, t, w, h, s, e};
		return d;
	endfunction

	// Queue a random set of n detections, the last one closing it
	task automatic queue_set(int n);
		det_item_t d;
		det_item_t base;
		for (int i = 0; i < n; i++) begin
			d = rand_det(i == n - 1);
			// often shift the previous box slightly so the same-class overlap test bites
			if (i > 0 && $urandom_range(2) == 0) begin
				base = pending_items[pending_items.size() - 1];
				d.class_id = base.class_id;
				d.left = 16'(base.left + $urandom_range(40));
				d.top = 16'(base.top + $urandom_range(40));
				d.width = base.width;
				d.height = base.height;
				if ($urandom_range(3) == 0)
					d.score = base.score;   // tie, order by arrival
			end
			queue_item(d);
		end
	endtask

	// Wait for the block to drain, then a little more since dropped items give no result
	task automatic drain_block();
		while (pending_items.size() > 0 || in_ch.valid || expected_kept.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [15:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == gcn_pkg::REG_SCORE_THR)
			min_score = val;
		else
			iou_q8 = val[8:0];
		@(posedge clk);
	endtask

	initial begin
		mismatches = 0;
		items_sent = 0;
		results_seen = 0;
		sets_closed = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 0;
		cfg_busy = 1'b0;
		min_score = '0;
		iou_q8 = gcn_pkg::IOU_THR_RESET;
		set_overflow = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, size limits, ties, thresholds, empty set, overlap
		queue_item(mk(8'd0, 16'h0000, 16'h0000, 16'd16, 16'd16, 16'hFFFF, 1'b0));
		queue_item(mk(8'd0, 16'h0001, 16'h0001, 16'd16, 16'd16, 16'hFFFF, 1'b0));
		queue_item(mk(8'd1, 16'h0001, 16'h0001, 16'd16, 16'd16, 16'h8000, 1'b0));
		queue_item(mk(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 1'b0));
		queue_item(mk(8'd2, 16'd100, 16'd100, 16'd15, 16'd40, 16'h7000, 1'b0));
		queue_item(mk(8'd2, 16'd100, 16'd100, 16'd40, 16'd15, 16'h7000, 1'b0));
		queue_item(mk(8'd2, 16'd100, 16'd100, 16'd40, 16'd40, 16'h0000, 1'b1));
		// empty set: only invalid detections
		queue_item(mk(8'hAA, 16'h5555, 16'hAAAA, 16'd0, 16'd0, 16'h5555, 1'b1));
		// touching but not overlapping, same class
		queue_item(mk(8'd3, 16'd0, 16'd0, 16'd32, 16'd32, 16'h1234, 1'b0));
		queue_item(mk(8'd3, 16'd32, 16'd0, 16'd32, 16'd32, 16'h1234, 1'b1));
		queue_set(8);
		drain_block();

		// Registers: threshold extremes, score filter on
		write_reg(gcn_pkg::REG_IOU_THR, 16'd0);
		write_reg(gcn_pkg::REG_SCORE_THR, 16'hFFFF);
		queue_item(mk(8'd5, 16'd10, 16'd10, 16'd64, 16'd64, 16'hFFFE, 1'b0));
		queue_item(mk(8'd5, 16'd10, 16'd10, 16'd64, 16'd64, 16'hFFFF, 1'b0));
		queue_item(mk(8'd5, 16'd70, 16'd70, 16'd64, 16'd64, 16'hFFFF, 1'b1));
		drain_block();
		write_reg(gcn_pkg::REG_IOU_THR, 16'h01FF);
		write_reg(gcn_pkg::REG_SCORE_THR, 16'd0);
		queue_item(mk(8'd6, 16'd10, 16'd10, 16'd64, 16'd64, 16'h4000, 1'b0));
		queue_item(mk(8'd6, 16'd10, 16'd10, 16'd64, 16'd64, 16'h4000, 1'b1));
		drain_block();
		write_reg(gcn_pkg::REG_IOU_THR, 16'd256);

		// Overflow: 66 valid detections into a 64 deep store
		for (int i = 0; i < 66; i++)
			queue_item(mk(8'($urandom_range(1)), 16'(i * 20), 16'd0, 16'd16,
				16'd16, 16'($urandom_range(1, 65535)), i == 65));
		drain_block();
		write_reg(gcn_pkg::REG_IOU_THR, 16'd115);

		// Random phases with different idling; long hold-off in the stalling phase
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
				default: begin send_idle_pct = 20; recv_stall_pct = 20; end
			endcase
			if (ph == 1)
				write_reg(gcn_pkg::REG_SCORE_THR, 16'h2000);
			if (ph == 3)
				write_reg(gcn_pkg::REG_IOU_THR, 16'($urandom_range(30, 200)));
			for (int s = 0; s < 4; s++)
				queue_set($urandom_range(3, 12));
			if (ph == 2)
				hold_off_cycles = 400;
			drain_block();
			if (ph == 1)
				write_reg(gcn_pkg::REG_SCORE_THR, 16'd0);
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;

		$display("Covered %0d detections in %0d sets, %0d results checked.",
			items_sent, sets_closed, results_seen);
		if (mismatches == 0 && expected_kept.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* sim.f */
hdl/gcn_pkg.sv
hdl/gcn_if.sv
hdl/gcn_sort_cell.sv
hdl/gcn_kept_cell.sv
hdl/greedy_class_nms.sv
tb/sv/tb_greedy_class_nms.sv
